// ===== sv/cat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and codes for the charger availability tracker: request and
// result layouts, connector table entry, command, level and error codes.
// ----------------------------------------------------------------------------
package cat_pkg;

    // Default sizing of the availability table.
    localparam int MAX_EVSES_DEF      = 8;
    localparam int MAX_CONNECTORS_DEF = 4;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_EVSE_COUNT       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONNECTOR_COUNTS = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [3:0]  EVSE_COUNT_RST       = 4'd1;
    localparam logic [23:0] CONNECTOR_COUNTS_RST = 24'h249249;

    // Command codes; the two unused codes behave as a query.
    localparam logic [2:0] CMD_SET_OPER  = 3'd0;
    localparam logic [2:0] CMD_SET_OCC   = 3'd1;
    localparam logic [2:0] CMD_SET_RES   = 3'd2;
    localparam logic [2:0] CMD_SET_FAULT = 3'd3;
    localparam logic [2:0] CMD_QUERY     = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;

    // Addressed level.
    localparam logic [1:0] LVL_STATION = 2'd0;
    localparam logic [1:0] LVL_EVSE    = 2'd1;
    localparam logic [1:0] LVL_CONN    = 2'd2;
    localparam logic [1:0] LVL_CONN_X  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_EVSE = 2'd1;
    localparam logic [1:0] ERR_CONN = 2'd2;

    // Effective connector states.
    localparam logic [2:0] CST_AVAILABLE   = 3'd0;
    localparam logic [2:0] CST_OCCUPIED    = 3'd1;
    localparam logic [2:0] CST_RESERVED    = 3'd2;
    localparam logic [2:0] CST_UNAVAILABLE = 3'd3;
    localparam logic [2:0] CST_FAULTED     = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] level;
        logic [3:0] evse_id;
        logic [2:0] conn_id;
        logic       value;
    } request_t;

    typedef struct packed {
        logic [1:0] error;
        logic       individual_operative;
        logic       effective_operative;
        logic [2:0] connector_state;
        logic       changed;
    } result_t;

    // One connector entry: own flags plus the last acknowledged state.
    typedef struct packed {
        logic       oper;
        logic       fault;
        logic       occ;
        logic       res;
        logic [2:0] ack;
    } conn_entry_t;

    localparam conn_entry_t CONN_ENTRY_RST = '{
        oper:  1'b1,
        fault: 1'b0,
        occ:   1'b0,
        res:   1'b0,
        ack:   CST_AVAILABLE
    };

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage
`default_nettype wire

// ===== sv/cat_conn_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cat_conn_mem
// Connector table: one synchronous memory with a registered read, per-entry
// valid bits so that unwritten entries read as the reset entry, and a
// write-first bypass when the read and write hit the same entry.
// ----------------------------------------------------------------------------
module cat_conn_mem #(
    parameter int DEPTH = cat_pkg::MAX_EVSES_DEF * cat_pkg::MAX_CONNECTORS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [AW-1:0]         rd_addr,
    output cat_pkg::conn_entry_t rd_data,
    input  wire                  wr_en,
    input  wire [AW-1:0]         wr_addr,
    input  cat_pkg::conn_entry_t wr_data
);

    cat_pkg::conn_entry_t mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    cat_pkg::conn_entry_t rd_data_reg;
    logic                 rd_valid_reg;
    logic                 bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, taking the entry being written in the same cycle.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= bypass ? wr_data : mem[rd_addr];
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= bypass || valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : cat_pkg::CONN_ENTRY_RST;

endmodule
`default_nettype wire

// ===== sv/charger_availability_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted request is registered and shown for one cycle
// with done high. A new request is accepted only once the last is through,
// as the registered read of the connector table is followed by its
// write-back; busy is high for the cycle between. Results cannot be
// stalled. Reset (rst_n low, asynchronous) marks every entry operative and
// available and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// charger_availability_tracker_core
// Three-level availability table (station, EVSE, connector) with set,
// query and acknowledge requests and effective status reporting.
// ----------------------------------------------------------------------------
module charger_availability_tracker_core #(
    parameter int MAX_EVSES      = cat_pkg::MAX_EVSES_DEF,
    parameter int MAX_CONNECTORS = cat_pkg::MAX_CONNECTORS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  cat_pkg::request_t                  request,
    output logic                               done,
    output cat_pkg::result_t                   result,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [cat_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [cat_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_EVSES * MAX_CONNECTORS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = (MAX_EVSES > 1) ? $clog2(MAX_EVSES) : 1;
    localparam logic [4:0] EVSE_MAX    = 5'(MAX_EVSES);
    localparam logic [2:0] CONN_MAX    = 3'(MAX_CONNECTORS);
    localparam logic [7:0] CONN_STRIDE = 8'(MAX_CONNECTORS);

    // Configuration registers.
    logic [3:0]  evse_count_reg;
    logic [23:0] connector_counts_reg;

    // Station and EVSE status flops.
    logic                 station_oper_reg, station_oper_next;
    logic                 station_ack_reg, station_ack_next;
    logic [MAX_EVSES-1:0] evse_oper_reg, evse_oper_next;
    logic [MAX_EVSES-1:0] evse_ack_reg, evse_ack_next;

    // Sequencer and latched request.
    cat_pkg::state_t state_reg, state_next;
    logic [2:0]      cmd_reg;
    logic [1:0]      lvl_reg;
    logic [1:0]      err_reg;
    logic [EW-1:0]   ei_reg;
    logic [AW-1:0]   addr_reg;
    logic            value_reg;

    logic             done_reg, done_next;
    cat_pkg::result_t result_reg, result_next;

    // Decode signals.
    logic          accept;
    logic [1:0]    lvl_dec;
    logic [3:0]    e_m1;
    logic [2:0]    c_m1;
    logic [5:0]    shift_amt;
    logic [23:0]   counts_shifted;
    logic [2:0]    conn_limit;
    logic [4:0]    evse_limit;
    logic          evse_bad;
    logic          conn_bad;
    logic [1:0]    err_dec;
    logic [EW-1:0] ei_dec;
    logic [AW-1:0] addr_dec;

    // Table interface.
    cat_pkg::conn_entry_t rd_entry;
    cat_pkg::conn_entry_t wr_entry;
    logic                 wr_en;

    assign busy      = (state_reg == cat_pkg::ST_EXEC);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evse_count_reg       <= cat_pkg::EVSE_COUNT_RST;
            connector_counts_reg <= cat_pkg::CONNECTOR_COUNTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cat_pkg::CFG_EVSE_COUNT:       evse_count_reg       <= cfg_data[3:0];
                cat_pkg::CFG_CONNECTOR_COUNTS: connector_counts_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Request decode: effective level, identifier checks and table address.
    always_comb
    begin
        lvl_dec = request.level;
        if ((request.cmd == cat_pkg::CMD_SET_OCC) || (request.cmd == cat_pkg::CMD_SET_RES)
            || (request.cmd == cat_pkg::CMD_SET_FAULT) || (request.level == cat_pkg::LVL_CONN_X))
        begin
            lvl_dec = cat_pkg::LVL_CONN;
        end

        e_m1 = request.evse_id - 4'd1;
        c_m1 = request.conn_id - 3'd1;

        // Counts beyond the packed word shift out to zero.
        shift_amt      = 6'(e_m1) * 6'd3;
        counts_shifted = connector_counts_reg >> shift_amt;
        conn_limit     = (counts_shifted[2:0] > CONN_MAX) ? CONN_MAX : counts_shifted[2:0];
        evse_limit     = ({1'b0, evse_count_reg} > EVSE_MAX) ? EVSE_MAX
                                                             : {1'b0, evse_count_reg};

        evse_bad = (request.evse_id == 4'd0) || ({1'b0, request.evse_id} > evse_limit);
        conn_bad = (request.conn_id == 3'd0) || (request.conn_id > conn_limit);

        if (lvl_dec == cat_pkg::LVL_STATION)
        begin
            err_dec = cat_pkg::ERR_OK;
        end
        else if (evse_bad)
        begin
            err_dec = cat_pkg::ERR_EVSE;
        end
        else if ((lvl_dec == cat_pkg::LVL_CONN) && conn_bad)
        begin
            err_dec = cat_pkg::ERR_CONN;
        end
        else
        begin
            err_dec = cat_pkg::ERR_OK;
        end

        ei_dec   = e_m1[EW-1:0];
        addr_dec = AW'(8'(e_m1) * CONN_STRIDE + 8'(c_m1));
    end

    // Latch the request at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= request.cmd;
            lvl_reg   <= lvl_dec;
            err_reg   <= err_dec;
            ei_reg    <= ei_dec;
            addr_reg  <= addr_dec;
            value_reg <= request.value;
        end
    end

    // Connector table; the read at acceptance lands in the execute cycle.
    cat_conn_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_conn_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (addr_dec),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_entry)
    );

    // Execute: update the addressed level and form the result.
    always_comb
    begin
        logic       ev_oper;
        logic       ev_eff;
        logic [2:0] cst;

        state_next        = state_reg;
        station_oper_next = station_oper_reg;
        station_ack_next  = station_ack_reg;
        evse_oper_next    = evse_oper_reg;
        evse_ack_next     = evse_ack_reg;
        done_next         = 1'b0;
        result_next       = '0;
        wr_en             = 1'b0;
        wr_entry          = rd_entry;
        ev_oper           = 1'b0;
        ev_eff            = 1'b0;
        cst               = cat_pkg::CST_AVAILABLE;

        case (state_reg)
            cat_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cat_pkg::ST_EXEC;
                end
            end

            cat_pkg::ST_EXEC:
            begin
                state_next = cat_pkg::ST_IDLE;
                done_next  = 1'b1;
                result_next.error = err_reg;
                if (err_reg == cat_pkg::ERR_OK)
                begin
                    case (lvl_reg)
                        cat_pkg::LVL_STATION:
                        begin
                            if (cmd_reg == cat_pkg::CMD_SET_OPER)
                            begin
                                station_oper_next = value_reg;
                            end
                            if (cmd_reg == cat_pkg::CMD_CLEAR)
                            begin
                                station_ack_next = station_oper_next;
                            end
                            result_next.individual_operative = station_oper_next;
                            result_next.effective_operative  = station_oper_next;
                            result_next.changed = station_oper_next != station_ack_next;
                        end

                        cat_pkg::LVL_EVSE:
                        begin
                            ev_oper = (cmd_reg == cat_pkg::CMD_SET_OPER) ? value_reg
                                                                         : evse_oper_reg[ei_reg];
                            ev_eff  = station_oper_reg & ev_oper;
                            evse_oper_next[ei_reg] = ev_oper;
                            if (cmd_reg == cat_pkg::CMD_CLEAR)
                            begin
                                evse_ack_next[ei_reg] = ev_eff;
                            end
                            result_next.individual_operative = ev_oper;
                            result_next.effective_operative  = ev_eff;
                            result_next.changed = ev_eff != evse_ack_next[ei_reg];
                        end

                        default:
                        begin
                            // Connector level: flag update, priority state, acknowledge.
                            case (cmd_reg)
                                cat_pkg::CMD_SET_OPER:  wr_entry.oper  = value_reg;
                                cat_pkg::CMD_SET_OCC:   wr_entry.occ   = value_reg;
                                cat_pkg::CMD_SET_RES:   wr_entry.res   = value_reg;
                                cat_pkg::CMD_SET_FAULT: wr_entry.fault = value_reg;
                                default:                ;
                            endcase
                            if (!station_oper_reg || !evse_oper_reg[ei_reg] || !wr_entry.oper)
                            begin
                                cst = cat_pkg::CST_UNAVAILABLE;
                            end
                            else if (wr_entry.fault)
                            begin
                                cst = cat_pkg::CST_FAULTED;
                            end
                            else if (wr_entry.occ)
                            begin
                                cst = cat_pkg::CST_OCCUPIED;
                            end
                            else if (wr_entry.res)
                            begin
                                cst = cat_pkg::CST_RESERVED;
                            end
                            else
                            begin
                                cst = cat_pkg::CST_AVAILABLE;
                            end
                            if (cmd_reg == cat_pkg::CMD_CLEAR)
                            begin
                                wr_entry.ack = cst;
                            end
                            wr_en = 1'b1;
                            result_next.individual_operative = wr_entry.oper;
                            result_next.effective_operative  =
                                (cst != cat_pkg::CST_UNAVAILABLE) && (cst != cat_pkg::CST_FAULTED);
                            result_next.connector_state = cst;
                            result_next.changed         = cst != wr_entry.ack;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = cat_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and status flops.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cat_pkg::ST_IDLE;
            station_oper_reg <= 1'b1;
            station_ack_reg  <= 1'b1;
            evse_oper_reg    <= '1;
            evse_ack_reg     <= '1;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            station_oper_reg <= station_oper_next;
            station_ack_reg  <= station_ack_next;
            evse_oper_reg    <= evse_oper_next;
            evse_ack_reg     <= evse_ack_next;
            done_reg         <= done_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule
`default_nettype wire
